@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define AST_HOLD(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition is followed in the next cycle by another.
`define AST_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");

`endif

@@ rtl/ntlm_pkg.sv @@
// Package: states, MD4 constants and round tables for the NTLM hash block.
`default_nettype none
package ntlm_pkg;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PADM = 5'b00010,
        ST_ZERO = 5'b00100,
        ST_COMP = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] K_R1   = 32'h5A827999;
    localparam logic [31:0] K_R2   = 32'h6ED9EBA1;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LAST_STEP = 6'd48;

    // Message word used by each of the 48 round steps.
    function automatic logic [3:0] msg_idx(input logic [5:0] step);
        logic [3:0] lo;
        lo = step[3:0];
        unique case (step[5:4])
            2'd0:    msg_idx = lo;
            2'd1:    msg_idx = {lo[1:0], lo[3:2]};
            default: msg_idx = {lo[0], lo[1], lo[2], lo[3]};
        endcase
    endfunction

    // Left rotation amount per round and position.
    function automatic logic [4:0] rot_amt(input logic [1:0] rnd, input logic [1:0] pos);
        logic [4:0] s;
        s = 5'd3;
        unique case ({rnd, pos})
            4'b0000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0100: s = 5'd3;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1000: s = 5'd3;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            4'b1011: s = 5'd15;
            default: s = 5'd3;
        endcase
        rot_amt = s;
    endfunction

    // Round function and additive constant.
    function automatic logic [31:0] round_f(input logic [1:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        unique case (rnd)
            2'd0:    round_f = (b & c) | (~b & d);
            2'd1:    round_f = ((b & c) | (b & d) | (c & d)) + K_R1;
            default: round_f = (b ^ c ^ d) + K_R2;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ rtl/ntlm_blk_ram.sv @@
// Block buffer: 16 x 32 memory, one write port, registered read port.
`default_nettype none
module ntlm_blk_ram (
    input  wire logic        clk,
    input  wire logic        we,
    input  wire logic [3:0]  waddr,
    input  wire logic [31:0] wdata,
    input  wire logic [3:0]  raddr,
    output logic      [31:0] rdata
);
    logic [31:0] mem [16];
    logic [31:0] rdata_reg;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

@@ rtl/ntlm_password_hash.sv @@
// Top level: NTLM password hash (MD4 over UTF-16LE characters).
//   channel  | direction | handshake           | payload
//   input    | in        | in_valid/in_stall   | char_byte, has_char, is_last
//   output   | out       | out_valid/out_stall | digest_word0..3
// A character item is written into the buffer memory; a 32nd character starts the
// compression (steps through the block memory's registered read port, then the add).
// The last item adds the padding write and zero fill of the buffer memory
// (one word a cycle) and one or two compressions, then waits in the output register.
// Reset loads the MD4 initial words; the input is stalled while a block is in work
// or a digest waits to be taken.
`default_nettype none
module ntlm_password_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_byte,
    input  wire logic        has_char,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] digest_word0,
    output logic      [31:0] digest_word1,
    output logic      [31:0] digest_word2,
    output logic      [31:0] digest_word3
);
    import ntlm_pkg::*;

    state_t      state_reg, state_next;
    logic [59:0] count_reg, count_next;
    logic [5:0]  step_reg, step_next;
    logic [3:0]  fill_reg, fill_next;
    logic        last_reg, last_next;
    logic        padded_reg, padded_next;
    logic        len_reg, len_next;
    logic [31:0] ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [31:0] ch_a_next, ch_b_next, ch_c_next, ch_d_next;
    logic [31:0] va_reg, vb_reg, vc_reg, vd_reg;
    logic [31:0] va_next, vb_next, vc_next, vd_next;
    logic [7:0]  pend_reg, pend_next;

    logic        we;
    logic [3:0]  waddr, raddr;
    logic [31:0] wdata, rdata;
    logic        in_acc, out_acc;
    logic [4:0]  pos;
    logic [5:0]  cur;
    logic [31:0] sum, rot_word;
    logic [63:0] rot_wide;

    ntlm_blk_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign pos       = count_reg[4:0];
    assign digest_word0 = ch_a_reg;
    assign digest_word1 = ch_b_reg;
    assign digest_word2 = ch_c_reg;
    assign digest_word3 = ch_d_reg;

    // Round step on the working words; the step in hand is one behind the read
    assign cur      = step_reg - 6'd1;
    assign raddr    = msg_idx(step_reg);
    assign sum      = va_reg + round_f(cur[5:4], vb_reg, vc_reg, vd_reg) + rdata;
    assign rot_wide = {sum, sum} << rot_amt(cur[5:4], cur[1:0]);
    assign rot_word = rot_wide[63:32];

    // Sequence the block buffer, padding and compression
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        fill_next   = fill_reg;
        last_next   = last_reg;
        padded_next = padded_reg;
        len_next    = len_reg;
        pend_next   = pend_reg;
        ch_a_next   = ch_a_reg;
        ch_b_next   = ch_b_reg;
        ch_c_next   = ch_c_reg;
        ch_d_next   = ch_d_reg;
        va_next     = va_reg;
        vb_next     = vb_reg;
        vc_next     = vc_reg;
        vd_next     = vd_reg;
        we          = 1'b0;
        waddr       = pos[4:1];
        wdata       = 32'h0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    last_next = is_last;
                    if (has_char)
                    begin
                        we         = 1'b1;
                        wdata      = pos[0] ? {8'h00, char_byte, 8'h00, pend_reg}
                                            : {24'h0, char_byte};
                        count_next = count_reg + 60'd1;
                        if (!pos[0])
                        begin
                            pend_next = char_byte;
                        end
                    end
                    if (has_char && (pos == 5'd31))
                    begin
                        step_next  = '0;
                        state_next = ST_COMP;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PADM;
                    end
                end
            end
            ST_PADM:
            begin
                we          = 1'b1;
                wdata       = pos[0] ? {8'h00, PAD_MARK, 8'h00, pend_reg}
                                     : {24'h0, PAD_MARK};
                padded_next = 1'b1;
                len_next    = (pos[4:2] != 3'b111);
                if (pos[4:1] == 4'd15)
                begin
                    step_next  = '0;
                    state_next = ST_COMP;
                end
                else
                begin
                    fill_next  = pos[4:1] + 4'd1;
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                we    = 1'b1;
                waddr = fill_reg;
                if (len_reg && (fill_reg == 4'd14))
                begin
                    wdata = {count_reg[27:0], 4'h0};
                end
                else if (len_reg && (fill_reg == 4'd15))
                begin
                    wdata = count_reg[59:28];
                end
                if (fill_reg == 4'd15)
                begin
                    step_next  = '0;
                    state_next = ST_COMP;
                end
                else
                begin
                    fill_next = fill_reg + 4'd1;
                end
            end
            ST_COMP:
            begin
                if (step_reg == '0)
                begin
                    va_next = ch_a_reg;
                    vb_next = ch_b_reg;
                    vc_next = ch_c_reg;
                    vd_next = ch_d_reg;
                    step_next = step_reg + 6'd1;
                end
                else if (step_reg != LAST_STEP + 6'd1)
                begin
                    va_next   = vd_reg;
                    vb_next   = rot_word;
                    vc_next   = vb_reg;
                    vd_next   = vc_reg;
                    step_next = step_reg + 6'd1;
                end
                else
                begin
                    // Fold the working words into the chain and pick the next job
                    ch_a_next = ch_a_reg + va_reg;
                    ch_b_next = ch_b_reg + vb_reg;
                    ch_c_next = ch_c_reg + vc_reg;
                    ch_d_next = ch_d_reg + vd_reg;
                    priority if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!padded_reg)
                    begin
                        state_next = ST_PADM;
                    end
                    else if (!len_reg)
                    begin
                        len_next   = 1'b1;
                        fill_next  = '0;
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    ch_a_next   = INIT_A;
                    ch_b_next   = INIT_B;
                    ch_c_next   = INIT_C;
                    ch_d_next   = INIT_D;
                    count_next  = '0;
                    last_next   = 1'b0;
                    padded_next = 1'b0;
                    len_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            fill_reg   <= '0;
            last_reg   <= 1'b0;
            padded_reg <= 1'b0;
            len_reg    <= 1'b0;
            ch_a_reg   <= INIT_A;
            ch_b_reg   <= INIT_B;
            ch_c_reg   <= INIT_C;
            ch_d_reg   <= INIT_D;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            fill_reg   <= fill_next;
            last_reg   <= last_next;
            padded_reg <= padded_next;
            len_reg    <= len_next;
            ch_a_reg   <= ch_a_next;
            ch_b_reg   <= ch_b_next;
            ch_c_reg   <= ch_c_next;
            ch_d_reg   <= ch_d_next;
        end
    end

    // Advance working words and the held low character
    always_ff @(posedge clk)
    begin
        va_reg   <= va_next;
        vb_reg   <= vb_next;
        vc_reg   <= vc_next;
        vd_reg   <= vd_next;
        pend_reg <= pend_next;
    end
endmodule
`default_nettype wire

@@ rtl/ntlm_checker.sv @@
// Port checker for the NTLM hash block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ntlm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        is_last,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] digest_word0
);
    `AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(digest_word0))
    `AST_HOLD(a_out_blocks_in, !out_valid || in_stall)
    `AST_NEXT(a_no_early_digest, in_valid && !in_stall && !is_last, !out_valid)
    `AST_NEXT(a_last_stalls, in_valid && !in_stall && is_last, in_stall)
endmodule

bind ntlm_password_hash ntlm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word0 (digest_word0)
);
`default_nettype wire

@@ test/tb_ntlm_password_hash.sv @@
// Testbench for the NTLM password hash block: MD4 digests of UTF-16LE passwords.
`default_nettype none
module tb_ntlm_password_hash;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_byte;
    logic        has_char;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } digest_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] ADD_R1 = 32'h5A827999;
    localparam logic [31:0] ADD_R2 = 32'h6ED9EBA1;
    localparam logic [31:0] PAD_BYTE = 32'h80;
    localparam int CYCLE_LIMIT = 2000000;

    digest_t     digest_q[$];
    logic [31:0] hash_state[4];
    logic [31:0] msg_block[16];
    logic [59:0] msg_chars;
    int          mismatches;
    int          digests_seen;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    ntlm_password_hash i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_byte(char_byte), .has_char(has_char), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word0(digest_word0), .digest_word1(digest_word1),
        .digest_word2(digest_word2), .digest_word3(digest_word3)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reload the chaining words and clear the running message
    function automatic void md4_restart();
        hash_state[0] = IV_A;
        hash_state[1] = IV_B;
        hash_state[2] = IV_C;
        hash_state[3] = IV_D;
        msg_chars = '0;
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
    endfunction

    function automatic logic [31:0] rol(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // Run the 48 MD4 steps over the current block and clear it
    function automatic void md4_compress();
        logic [31:0] v[4];
        logic [31:0] b, c, d, f, k;
        int rnd, pos, ta, mi, sh;
        int rots[3][4];
        rots = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};
        for (int i = 0; i < 4; i++)
            v[i] = hash_state[i];
        for (int i = 0; i < 48; i++)
        begin
            rnd = i / 16;
            pos = i % 4;
            ta = (4 - pos) % 4;
            b = v[(ta + 1) % 4];
            c = v[(ta + 2) % 4];
            d = v[(ta + 3) % 4];
            if (rnd == 0)
            begin
                f = (b & c) | (~b & d);
                k = '0;
                mi = i;
            end
            else if (rnd == 1)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = ADD_R1;
                mi = (i % 4) * 4 + (i % 16) / 4;
            end
            else
            begin
                f = b ^ c ^ d;
                k = ADD_R2;
                sh = i % 16;
                mi = ((sh & 1) << 3) | ((sh & 2) << 1) | ((sh & 4) >> 1) | ((sh & 8) >> 3);
            end
            v[ta] = rol(v[ta] + f + msg_block[mi] + k, rots[rnd][pos]);
        end
        for (int i = 0; i < 4; i++)
        begin
            hash_state[i] = hash_state[i] + v[i];
        end
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
    endfunction

    // Advance the hash by one item; queue a digest on the last one
    function automatic void ntlm_absorb(logic [7:0] ch, logic has, logic last);
        int p;
        logic [63:0] bits;
        digest_t dg;
        if (has)
        begin
            p = int'(msg_chars[4:0]);
            msg_block[p / 2] |= {24'h0, ch} << (16 * (p % 2));
            msg_chars = msg_chars + 60'd1;
            if (msg_chars[4:0] == 5'd0)
                md4_compress();
        end
        if (last)
        begin
            p = int'(msg_chars[4:0]);
            msg_block[p / 2] |= PAD_BYTE << (16 * (p % 2));
            if (p >= 28)
                md4_compress();
            bits = {msg_chars, 4'h0};
            msg_block[14] = bits[31:0];
            msg_block[15] = bits[63:32];
            md4_compress();
            dg = '{hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
            digest_q.push_back(dg);
            md4_restart();
        end
    endfunction

    // Offer one transaction, with random idle cycles before it
    task automatic send_item(logic [7:0] ch, logic has, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= ch;
        has_char  <= has;
        is_last   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ntlm_absorb(ch, has, last);
        @(negedge clk);
    endtask

    task automatic send_password(int len);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(255)), 1'b1, i == len - 1);
    endtask

    // Drive receiver stall at the falling edge
    always @(negedge clk)
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Compare each delivered digest with the oldest one predicted
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            digests_seen++;
            if (digest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest %h %h %h %h",
                             digest_word0, digest_word1, digest_word2, digest_word3);
            end
            else
            begin
                digest_t exp_d;
                exp_d = digest_q.pop_front();
                if (exp_d.w0 !== digest_word0 || exp_d.w1 !== digest_word1 ||
                    exp_d.w2 !== digest_word2 || exp_d.w3 !== digest_word3)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: expected %h %h %h %h got %h %h %h %h",
                                 exp_d.w0, exp_d.w1, exp_d.w2, exp_d.w3,
                                 digest_word0, digest_word1, digest_word2, digest_word3);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_password(27);
        send_password(28);
    endtask

    task automatic test_block_edges();
        send_password(31);
        send_password(32);
        for (int i = 0; i < 32; i++)
            send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_password(33);
        send_password(60);
        send_password(64);
        send_password(70);
    endtask

    // Mostly well-formed passwords, some empty items and bare endings
    task automatic test_random(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(100, 33) : $urandom_range(1, 33);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(15) == 0)
                begin
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                    sent++;
                end
                send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            end
            if ($urandom_range(3) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            else
                send_item(8'($urandom_range(255)), 1'b1, 1'b1);
            sent += len + 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_byte = '0;
        has_char = 1'b0;
        is_last = 1'b0;
        out_stall = 1'b0;
        mismatches = 0;
        digests_seen = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        md4_restart();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_block_edges();
        send_idle_pct = 19;
        recv_idle_pct = 72;
        test_random(330);
        send_idle_pct = 72;
        recv_idle_pct = 19;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(330);
        in_valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/ntlm_pkg.sv
rtl/ntlm_blk_ram.sv
rtl/ntlm_password_hash.sv
rtl/ntlm_checker.sv
test/tb_ntlm_password_hash.sv
